### hdl/b2bcd_pkg.sv
`timescale 1ns / 1ps

package b2bcd_pkg;

  // Input value width; one double-dabble cell per input bit
  localparam int VALUE_W = 32;
  // Decimal digits needed to hold any VALUE_W-bit value
  localparam int MAX_DIGITS = 10;
  localparam int BCD_W = 4 * MAX_DIGITS;
  // Digits carried by the result field
  localparam int FIELD_DIGITS = 8;
  localparam int OUT_W = 4 * FIELD_DIGITS;
  // Digits used in four-digit mode
  localparam int SHORT_DIGITS = 4;
  // Default digit count
  localparam int DIGIT_COUNT_DEF = 8;

  localparam logic [3:0] NINE = 4'd9;

  // Data carried from cell to cell
  typedef struct packed {
    logic [VALUE_W-1:0] bin;
    logic [BCD_W-1:0]   bcd;
  } b2bcd_beat_t;

  // True when every nibble of a result is a legal decimal digit
  function automatic logic bcd_legal(input logic [OUT_W-1:0] word);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < FIELD_DIGITS; i++) begin
      if (word[4*i +: 4] > NINE) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

### hdl/b2bcd_cell.sv
`timescale 1ns / 1ps

module b2bcd_cell
  import b2bcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  b2bcd_beat_t beat_i,
  output logic        ready_o,
  output logic        valid_o,
  output b2bcd_beat_t beat_o,
  input  logic        ready_i
);

  logic        valid_q, valid_d;
  b2bcd_beat_t beat_q, beat_d;
  logic [BCD_W-1:0] adj;

  // Add 3 to every digit of 5 or more, then shift one binary bit in
  always_comb begin
    adj = beat_i.bcd;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      if (beat_i.bcd[4*d +: 4] >= 4'd5) adj[4*d +: 4] = beat_i.bcd[4*d +: 4] + 4'd3;
    end
    beat_d.bcd = {adj[BCD_W-2:0], beat_i.bin[VALUE_W-1]};
    beat_d.bin = {beat_i.bin[VALUE_W-2:0], 1'b0};
  end

  // Stage moves when empty or when the next stage takes its beat
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

### hdl/b2bcd_out.sv
`timescale 1ns / 1ps

module b2bcd_out
  import b2bcd_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [BCD_W-1:0] bcd_i,
  input  logic             four_digit_mode_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [OUT_W-1:0] bcd_digits_o,
  output logic             overflow_o
);

  // Digits in use, clamped to the field and to four in short mode
  localparam int BASE_DIGITS  = (DIGIT_COUNT > FIELD_DIGITS) ? FIELD_DIGITS :
                                (DIGIT_COUNT < 1) ? 1 : DIGIT_COUNT;
  localparam int SHORT_USED   = (BASE_DIGITS > SHORT_DIGITS) ? SHORT_DIGITS : BASE_DIGITS;

  logic [3:0]       used;
  logic             ovf;
  logic [OUT_W-1:0] digits;
  logic             valid_q, valid_d;
  logic [OUT_W-1:0] digits_q;
  logic             ovf_q;

  assign used = four_digit_mode_i ? 4'(SHORT_USED) : 4'(BASE_DIGITS);

  // Overflow when any digit above those in use is nonzero; then saturate
  always_comb begin
    ovf = 1'b0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (4'(i) >= used && bcd_i[4*i +: 4] != 4'd0) ovf = 1'b1;
    end
    digits = '0;
    for (int i = 0; i < FIELD_DIGITS; i++) begin
      if (4'(i) < used) digits[4*i +: 4] = ovf ? NINE : bcd_i[4*i +: 4];
    end
  end

  // Output register; refills while its beat is being taken
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      digits_q <= digits;
      ovf_q    <= ovf;
    end
  end

  assign out_valid_o  = valid_q;
  assign bcd_digits_o = digits_q;
  assign overflow_o   = ovf_q;

endmodule

### hdl/binary_to_bcd_converter.sv
`timescale 1ns / 1ps

// Binary to packed BCD converter. Each beat on the input channel carries a
// 32-bit unsigned value; the matching output beat carries its decimal digits,
// four bits each, least significant digit in bits 3:0, plus an overflow flag.
// A value that does not fit in the digits in use (DIGIT_COUNT, at most eight,
// or four with four_digit_mode set) raises overflow and reads as all nines.
// The value passes through a row of 32 double-dabble cells, one per input
// bit, then an output register. One beat is taken every cycle unless
// in_stall_o is raised. Stages with no beat close up, so input beats keep
// entering while a result waits at a stalled output. Write four_digit_mode
// only while no beat is in flight.

module binary_to_bcd_converter
  import b2bcd_pkg::*;
#(
  parameter int DIGIT_COUNT = DIGIT_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [VALUE_W-1:0]  value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OUT_W-1:0]    bcd_digits_o,
  output logic                overflow_o
);

  logic        mode_q, mode_d;
  logic        valid  [VALUE_W+1];
  logic        ready  [VALUE_W+1];
  b2bcd_beat_t beat   [VALUE_W+1];

  // Mode register
  assign mode_d = cfg_we_i ? cfg_wdata_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  // Head of the cell row
  assign valid[0]    = in_valid_i;
  assign beat[0].bin = value_i;
  assign beat[0].bcd = '0;
  assign in_stall_o  = !ready[0];

  // One double-dabble step per cell
  for (genvar k = 0; k < VALUE_W; k++) begin : g_cell
    b2bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .beat_i  (beat[k]),
      .ready_o (ready[k]),
      .valid_o (valid[k+1]),
      .beat_o  (beat[k+1]),
      .ready_i (ready[k+1])
    );
  end

  // Digit selection, saturation and output register
  b2bcd_out #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_out (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (valid[VALUE_W]),
    .bcd_i             (beat[VALUE_W].bcd),
    .four_digit_mode_i (mode_q),
    .ready_o           (ready[VALUE_W]),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .bcd_digits_o      (bcd_digits_o),
    .overflow_o        (overflow_o)
  );

  // An empty output register never holds back the cell row
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // Every result nibble is a decimal digit
  a_digits_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bcd_legal(bcd_digits_o))
    else $error("illegal BCD digit in result");

  // Four-digit mode leaves the upper digits zero
  a_short_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_q |-> bcd_digits_o[OUT_W-1:4*SHORT_DIGITS] == '0)
    else $error("upper digits set in four-digit mode");

  // Overflow saturates the low digit to nine
  a_overflow_nines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> bcd_digits_o[3:0] == NINE)
    else $error("overflow result not saturated");

endmodule
